>>> hdl/bmrd_pkg.sv
// ----------------------------------------------------------------------------
// bmrd_pkg
// Shared constants for the below-mean run detector: field widths, register
// indexes, register reset values and the result queue geometry.
// ----------------------------------------------------------------------------
package bmrd_pkg;

    localparam int RADIUS_W = 20;
    localparam int MARGIN_W = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_RADIUS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFECT_MARGIN = 1'b1;

    localparam logic [RADIUS_W-1:0] MEAN_RADIUS_RESET = 20'd420000;
    localparam logic [MARGIN_W-1:0] DEFECT_MARGIN_RESET = 16'd50;

    // Result queue: four entries, room for two results is needed to accept
    // a transaction.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

endpackage

>>> hdl/below_mean_run_detector.sv
// ----------------------------------------------------------------------------
// below_mean_run_detector
// Finds stretches of wheel radius samples lying more than a margin below the
// mean radius over one revolution, and reports each stretch as a result.
// ----------------------------------------------------------------------------
// A sample's results are written into the result queue when its sample's
// transaction completes. Throughput: one sample per cycle while the output
// side keeps up; a sample that yields two results needs two output transactions,
// and the four-entry result queue accepts a sample only when two entries are free.
// Reset (rst_n, asynchronous, active low) clears the run state and the queue
// and loads the register reset values.
// ----------------------------------------------------------------------------
module below_mean_run_detector
    import bmrd_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [RADIUS_W-1:0]         radius_sample,
    input  logic                        final_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [$clog2(MAX_SAMPLES)-1:0] run_start,
    output logic [$clog2(MAX_SAMPLES):0]   run_end,
    output logic [$clog2(MAX_SAMPLES):0]   run_count,
    output logic [RADIUS_W-1:0]         run_depth,
    output logic                        last_of_item
);

    // Sample indexes run from 0 to MAX_SAMPLES-1; end and count can reach
    // MAX_SAMPLES itself and so carry one more bit.
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int RES_W = IDX_W + 2 * (IDX_W + 1) + RADIUS_W + 1;

    logic             fire;
    logic [1:0]       push_count;
    logic [RES_W-1:0] res0;
    logic [RES_W-1:0] res1;
    logic [RES_W-1:0] out_data;
    logic             has_room;

    // The input side only depends on room in the result queue, so a new
    // transaction is taken while older results still wait at the output.
    assign in_ready = has_room;
    assign fire     = in_valid && in_ready;

    // All per-sample work: defect compare, min/max tracking, run closing,
    // holding of the run that starts at index 0 and the merge at the wrap.
    bmrd_core #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .IDX_W       (IDX_W),
        .RES_W       (RES_W)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fire          (fire),
        .radius_sample (radius_sample),
        .final_sample  (final_sample),
        .push_count    (push_count),
        .res0          (res0),
        .res1          (res1)
    );

    // The results of a sample enter the queue together, in output order,
    // only when the sample's transaction completes.
    bmrd_out_queue #(
        .WIDTH (RES_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (fire ? push_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .has_room   (has_room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Unpack the queue head into the result fields.
    assign {run_start, run_end, run_count, run_depth, last_of_item} = out_data;

endmodule

>>> hdl/bmrd_core.sv
// ----------------------------------------------------------------------------
// bmrd_core
// Run tracking state and the per-sample logic. On each accepted sample it
// updates the state and presents up to two packed results for the queue.
// ----------------------------------------------------------------------------
module bmrd_core
    import bmrd_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int IDX_W = 12,
    parameter int RES_W = 59
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   fire,
    input  logic [RADIUS_W-1:0]    radius_sample,
    input  logic                   final_sample,
    output logic [1:0]             push_count,
    output logic [RES_W-1:0]       res0,
    output logic [RES_W-1:0]       res1
);

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MAX_SAMPLES - 1);

    logic [RADIUS_W-1:0] mean_radius_reg;
    logic [MARGIN_W-1:0] defect_margin_reg;

    logic [IDX_W-1:0]    sample_index_reg, sample_index_next;
    logic                in_run_reg, in_run_next;
    logic [IDX_W-1:0]    current_start_reg, current_start_next;
    logic [RADIUS_W-1:0] current_min_reg, current_min_next;
    logic [RADIUS_W-1:0] current_max_reg, current_max_next;
    logic                leading_valid_reg, leading_valid_next;
    logic [IDX_W:0]      leading_end_reg, leading_end_next;
    logic [RADIUS_W-1:0] leading_depth_reg, leading_depth_next;

    logic                defect;
    logic                fin;
    logic                close_run;
    logic                close_leading;
    logic                close_emit;
    logic                trail_emit;
    logic                trail_merge;
    logic                lead_emit;
    logic [IDX_W:0]      idx_ext;
    logic [IDX_W:0]      end_ext;
    logic [IDX_W:0]      start_ext;
    logic [RADIUS_W-1:0] close_depth;
    logic [RADIUS_W-1:0] trail_depth;
    logic [RADIUS_W-1:0] merge_depth;
    logic [RES_W-1:0]    close_res;
    logic [RES_W-1:0]    trail_res;
    logic [RES_W-1:0]    lead_res;
    logic [RES_W-1:0]    first_res;
    logic                first_emit;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_radius_reg   <= MEAN_RADIUS_RESET;
            defect_margin_reg <= DEFECT_MARGIN_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MEAN_RADIUS:   mean_radius_reg   <= cfg_data[RADIUS_W-1:0];
                CFG_DEFECT_MARGIN: defect_margin_reg <= cfg_data[MARGIN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        defect = ({1'b0, radius_sample} + {{(RADIUS_W + 1 - MARGIN_W){1'b0}},
                  defect_margin_reg}) < {1'b0, mean_radius_reg};
        fin = final_sample || (sample_index_reg == LAST_INDEX);
        idx_ext = {1'b0, sample_index_reg};
        end_ext = idx_ext + 1'b1;

        // Running run state after this sample.
        current_start_next = current_start_reg;
        current_min_next   = current_min_reg;
        current_max_next   = current_max_reg;
        if (defect && !in_run_reg)
        begin
            current_start_next = sample_index_reg;
            current_min_next   = radius_sample;
            current_max_next   = radius_sample;
        end
        else if (defect)
        begin
            if (radius_sample < current_min_reg)
                current_min_next = radius_sample;
            if (radius_sample > current_max_reg)
                current_max_next = radius_sample;
        end

        // A clean sample closes an open run; a run from index 0 is held.
        close_run     = !defect && in_run_reg;
        close_leading = close_run && (current_start_reg == '0);
        close_emit    = close_run && !close_leading;
        close_depth   = current_max_reg - current_min_reg;

        leading_end_next   = leading_end_reg;
        leading_depth_next = leading_depth_reg;
        if (close_leading)
        begin
            leading_end_next   = idx_ext;
            leading_depth_next = close_depth;
        end
        leading_valid_next = leading_valid_reg || close_leading;

        // End of revolution: trailing run, possibly merged across the wrap.
        start_ext   = {1'b0, current_start_next};
        trail_depth = current_max_next - current_min_next;
        trail_emit  = fin && defect;
        trail_merge = trail_emit && leading_valid_next && (current_start_next != '0);
        merge_depth = (trail_depth > leading_depth_next) ? trail_depth
                                                         : leading_depth_next;
        lead_emit   = fin && leading_valid_next && !trail_merge;

        close_res = {current_start_reg, idx_ext, idx_ext - {1'b0, current_start_reg},
                     close_depth, 1'b0};
        if (trail_merge)
            trail_res = {current_start_next, leading_end_next,
                         (end_ext - start_ext) + leading_end_next, merge_depth, 1'b0};
        else
            trail_res = {current_start_next, end_ext, end_ext - start_ext,
                         trail_depth, 1'b0};
        lead_res = {{IDX_W{1'b0}}, leading_end_next, leading_end_next,
                    leading_depth_next, 1'b0};

        // Close and trailing results never occur together.
        first_emit = close_emit || trail_emit;
        first_res  = close_emit ? close_res : trail_res;
        res1 = lead_res;
        res1[0] = 1'b1;
        if (first_emit)
        begin
            res0 = first_res;
            res0[0] = !lead_emit;
            push_count = lead_emit ? 2'd2 : 2'd1;
        end
        else
        begin
            res0 = res1;
            push_count = lead_emit ? 2'd1 : 2'd0;
        end

        if (fin)
        begin
            sample_index_next = '0;
            in_run_next = 1'b0;
            leading_valid_next = 1'b0;
        end
        else
        begin
            sample_index_next = end_ext[IDX_W-1:0];
            in_run_next = defect;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg  <= '0;
            in_run_reg        <= 1'b0;
            current_start_reg <= '0;
            current_min_reg   <= '0;
            current_max_reg   <= '0;
            leading_valid_reg <= 1'b0;
            leading_end_reg   <= '0;
            leading_depth_reg <= '0;
        end
        else if (fire)
        begin
            sample_index_reg  <= sample_index_next;
            in_run_reg        <= in_run_next;
            current_start_reg <= current_start_next;
            current_min_reg   <= current_min_next;
            current_max_reg   <= current_max_next;
            leading_valid_reg <= leading_valid_next;
            leading_end_reg   <= leading_end_next;
            leading_depth_reg <= leading_depth_next;
        end
    end

endmodule

>>> hdl/bmrd_out_queue.sv
// ----------------------------------------------------------------------------
// bmrd_out_queue
// Small result queue that takes up to two entries per cycle and hands out
// one entry per output transaction.
// ----------------------------------------------------------------------------
module bmrd_out_queue
    import bmrd_pkg::*;
#(
    parameter int WIDTH = 59
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  logic [WIDTH-1:0] push0,
    input  logic [WIDTH-1:0] push1,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0]       entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_inc;
    logic                   pop;

    always_comb
    begin
        pop         = out_valid && out_ready;
        wr_ptr_inc  = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(pop);
    end

    assign has_room  = count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_inc] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the below-mean run detector. A short table of
// hand-picked samples covers the reset settings, the extremes and the wrap
// cases. It is followed by random revolutions under several register
// settings. Every result transaction is compared with the expected runs,
// typed into the table or taken from a bench-side tracker of the run state.
// ----------------------------------------------------------------------------
module tb_top;
    import bmrd_pkg::*;

    localparam int MAX_SAMPLES = 4096;
    localparam int START_W = $clog2(MAX_SAMPLES);
    localparam int INDEX_W = START_W + 1;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

    // The watchdog limit lies well above the longest stretch without a
    // transaction on either side that a healthy run can produce.
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles after the last expected result, in which any straggling
    // result would show up.
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 200;
    localparam int N_PHASES = 8;
    localparam int REPORT_LIMIT = 10;

    // One reported run, laid out like the result ports.
    typedef struct packed {
        logic [START_W-1:0]  run_start;
        logic [INDEX_W-1:0]  run_end;
        logic [INDEX_W-1:0]  run_count;
        logic [RADIUS_W-1:0] run_depth;
        logic                last;
    } run_t;

    // How a row of the directed table gets its expected results: from the
    // tracker, or typed into the table itself.
    typedef enum logic [1:0] {
        FROM_MODEL,
        TYPED_NONE,
        TYPED_ONE,
        TYPED_TWO
    } row_kind_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                fin;
        row_kind_t           kind;
        run_t                first;
        run_t                second;
    } row_t;

    // Shapes of random revolutions.
    typedef enum int {
        STYLE_RUNS,
        STYLE_WRAP,
        STYLE_NOISE
    } rev_style_t;

    localparam run_t NO_RUN = '0;

    // The directed walk runs with the reset settings: mean 420000 and margin
    // 50, so a sample is below the mean by enough when it is under 419950.
    localparam int N_DIRECTED = 20;
    localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // A run opens at index 0 and is held back; the largest sample ends it.
        '{20'd0,       1'b0, TYPED_NONE, NO_RUN, NO_RUN},
        '{20'hFFFFF,   1'b0, TYPED_NONE, NO_RUN, NO_RUN},
        // A run from index 2, closed by a sample right at the threshold.
        '{20'd419949,  1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd100,     1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd419950,  1'b0, TYPED_ONE,
            '{12'd2, 13'd4, 13'd2, 20'd419849, 1'b1}, NO_RUN},
        // The final sample starts a run, which merges with the held one.
        '{20'd5,       1'b1, TYPED_ONE,
            '{12'd5, 13'd1, 13'd2, 20'd0, 1'b1}, NO_RUN},
        // The whole revolution is one run and is reported once.
        '{20'd7,       1'b0, TYPED_NONE, NO_RUN, NO_RUN},
        '{20'd9,       1'b1, TYPED_ONE,
            '{12'd0, 13'd2, 13'd2, 20'd2, 1'b1}, NO_RUN},
        // A revolution without any run yields nothing.
        '{20'd500000,  1'b0, TYPED_NONE, NO_RUN, NO_RUN},
        '{20'd500000,  1'b1, TYPED_NONE, NO_RUN, NO_RUN},
        // The final sample closes an open run; the held run follows it.
        '{20'd10,      1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd600000,  1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd20,      1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd30,      1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd700000,  1'b1, TYPED_TWO,
            '{12'd2, 13'd4, 13'd2, 20'd10, 1'b0},
            '{12'd0, 13'd1, 13'd1, 20'd0, 1'b1}},
        // Single-sample revolutions, one defect and one clean.
        '{20'd0,       1'b1, TYPED_ONE,
            '{12'd0, 13'd1, 13'd1, 20'd0, 1'b1}, NO_RUN},
        '{20'hFFFFF,   1'b1, TYPED_NONE, NO_RUN, NO_RUN},
        // A run reaches the final sample with nothing held back.
        '{20'd600000,  1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd419949,  1'b0, FROM_MODEL, NO_RUN, NO_RUN},
        '{20'd1000,    1'b1, TYPED_ONE,
            '{12'd1, 13'd3, 13'd2, 20'd418949, 1'b1}, NO_RUN}
    };

    // Clock, reset and the block's inputs, all known from time zero.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MEAN_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic [RADIUS_W-1:0] radius_sample = '0;
    logic final_sample = 1'b0;
    logic out_ready = 1'b0;

    logic in_ready;
    logic out_valid;
    logic [START_W-1:0] run_start;
    logic [INDEX_W-1:0] run_end;
    logic [INDEX_W-1:0] run_count;
    logic [RADIUS_W-1:0] run_depth;
    logic last_of_item;

    // Tracker copy of the registers and of the run state.
    logic [RADIUS_W-1:0] trk_mean = MEAN_RADIUS_RESET;
    logic [MARGIN_W-1:0] trk_margin = DEFECT_MARGIN_RESET;
    logic [START_W-1:0]  trk_index = '0;
    logic                trk_in_run = 1'b0;
    logic [START_W-1:0]  trk_start = '0;
    logic [RADIUS_W-1:0] trk_min = '0;
    logic [RADIUS_W-1:0] trk_max = '0;
    logic                trk_lead_valid = 1'b0;
    logic [INDEX_W-1:0]  trk_lead_end = '0;
    logic [RADIUS_W-1:0] trk_lead_depth = '0;

    // Runs caused by the latest sample, and the runs still awaited.
    run_t step_runs [2];
    run_t pending_runs [$];

    int mismatches = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    below_mean_run_detector #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .radius_sample(radius_sample),
        .final_sample (final_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .run_start    (run_start),
        .run_end      (run_end),
        .run_count    (run_count),
        .run_depth    (run_depth),
        .last_of_item (last_of_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic run_t make_run(input int unsigned s, input int unsigned e,
                                      input int unsigned c, input int unsigned d);
        run_t r;
        r.run_start = s[START_W-1:0];
        r.run_end = e[INDEX_W-1:0];
        r.run_count = c[INDEX_W-1:0];
        r.run_depth = d[RADIUS_W-1:0];
        r.last = 1'b0;
        return r;
    endfunction

    // Advances the tracked run state by one sample and leaves the runs that
    // the sample reports in step_runs. Returns how many there are.
    function automatic int track_sample(input logic [RADIUS_W-1:0] radius,
                                        input logic fin_flag);
        int unsigned idx;
        int unsigned stop;
        int unsigned depth;
        int unsigned merged;
        bit fin;
        bit defect;
        int k;
        idx = 32'(trk_index);
        fin = fin_flag;
        defect = (int'(radius) + int'(trk_margin)) < int'(trk_mean);
        k = 0;

        // The last slot of the sample buffer always ends the revolution.
        if (idx + 1 >= MAX_SAMPLES)
            fin = 1'b1;

        if (defect)
        begin
            if (!trk_in_run)
            begin
                trk_in_run = 1'b1;
                trk_start = idx[START_W-1:0];
                trk_min = radius;
                trk_max = radius;
            end
            else
            begin
                if (radius < trk_min)
                    trk_min = radius;
                if (radius > trk_max)
                    trk_max = radius;
            end
        end
        else if (trk_in_run)
        begin
            trk_in_run = 1'b0;
            if (trk_start == 0)
            begin
                // A run from index 0 waits for the end of the revolution.
                trk_lead_valid = 1'b1;
                trk_lead_end = idx[INDEX_W-1:0];
                trk_lead_depth = trk_max - trk_min;
            end
            else
            begin
                step_runs[k] = make_run(32'(trk_start), idx, idx - 32'(trk_start),
                                        32'(trk_max - trk_min));
                k++;
            end
        end

        if (fin)
        begin
            stop = idx + 1;
            if (trk_in_run)
            begin
                depth = 32'(trk_max - trk_min);
                if (trk_lead_valid && trk_start != 0)
                begin
                    // The trailing run continues into the held one across the wrap.
                    merged = (depth > 32'(trk_lead_depth)) ? depth : 32'(trk_lead_depth);
                    step_runs[k] = make_run(32'(trk_start), 32'(trk_lead_end),
                                            (stop - 32'(trk_start)) + 32'(trk_lead_end),
                                            merged);
                    trk_lead_valid = 1'b0;
                end
                else
                begin
                    step_runs[k] = make_run(32'(trk_start), stop, stop - 32'(trk_start),
                                            depth);
                end
                k++;
            end
            if (trk_lead_valid)
            begin
                step_runs[k] = make_run(0, 32'(trk_lead_end), 32'(trk_lead_end),
                                        32'(trk_lead_depth));
                k++;
            end
            trk_index = '0;
            trk_in_run = 1'b0;
            trk_lead_valid = 1'b0;
        end
        else
        begin
            trk_index = trk_index + 1'b1;
        end

        if (k > 0)
            step_runs[k-1].last = 1'b1;
        return k;
    endfunction

    // Picks a radius on the wanted side of a nonzero threshold, with the
    // values right at the threshold and the field extremes drawn often.
    function automatic logic [RADIUS_W-1:0] pick_radius(input bit want_defect);
        int unsigned thr;
        int unsigned roll;
        logic [31:0] raw;
        thr = (trk_mean > RADIUS_W'(trk_margin)) ? 32'(trk_mean - RADIUS_W'(trk_margin)) : 0;
        roll = $urandom_range(7, 0);
        raw = $urandom;
        if (thr == 0)
            return raw[RADIUS_W-1:0];
        if (want_defect)
        begin
            if (roll == 0)
                return RADIUS_W'(thr - 1);
            if (roll == 1)
                return '0;
            raw = $urandom_range(thr - 1, 0);
            return raw[RADIUS_W-1:0];
        end
        if (roll == 0)
            return RADIUS_W'(thr);
        if (roll == 1)
            return RADIUS_MAX;
        raw = $urandom_range(32'(RADIUS_MAX), thr);
        return raw[RADIUS_W-1:0];
    endfunction

    // Offers one sample transaction and queues what it should produce. The
    // caller is always at a rising edge, and valid is only touched once per
    // edge: lowered when a gap follows, or left high for a back-to-back item.
    task automatic send_sample(input logic [RADIUS_W-1:0] radius, input logic fin,
                               input row_kind_t kind, input run_t typed_first,
                               input run_t typed_second);
        int gap;
        int n;
        gap = tx_burst ? 0 : $urandom_range(16, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        radius_sample <= radius;
        final_sample <= fin;
        do
            @(posedge clk);
        while (!in_ready);

        // The tracker always advances; typed rows replace its prediction.
        n = track_sample(radius, fin);
        case (kind)
            FROM_MODEL:
            begin
                for (int i = 0; i < n; i++)
                    pending_runs.push_back(step_runs[i]);
            end
            TYPED_ONE:
                pending_runs.push_back(typed_first);
            TYPED_TWO:
            begin
                pending_runs.push_back(typed_first);
                pending_runs.push_back(typed_second);
            end
            default:
            begin
            end
        endcase
    endtask

    // Sends one revolution of samples. Runs flip in and out at random; the
    // wrap style forces runs at both ends so that they merge across the wrap,
    // and noise ignores the threshold and raises the final flag at random.
    task automatic send_revolution(input int len, input rev_style_t style);
        int wrap_at;
        bit want;
        logic fin;
        logic [RADIUS_W-1:0] radius;
        logic [31:0] raw;
        wrap_at = (len < MAX_SAMPLES) ? len : MAX_SAMPLES;
        tx_burst = ($urandom_range(3, 0) == 0);
        want = ($urandom_range(1, 0) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(3, 0) == 0)
                want = !want;
            if (style == STYLE_WRAP && (i < 3 || (i >= wrap_at - 3 && i < wrap_at)))
                want = 1'b1;
            if (style == STYLE_NOISE)
            begin
                raw = $urandom;
                radius = raw[RADIUS_W-1:0];
                fin = ($urandom_range(7, 0) == 0);
            end
            else
            begin
                radius = pick_radius(want);
                fin = (i == len - 1);
            end
            send_sample(radius, fin, FROM_MODEL, NO_RUN, NO_RUN);
            items_sent++;
        end
    endtask

    // Brings the block to idle: no sample offered, every expected result
    // received, and a quiet stretch for anything unexpected to show up.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on consecutive edges, then waits with the write
    // enable low so that no sample can be accepted together with a register write.
    task automatic write_config(input logic [CFG_DATA_W-1:0] mean,
                                input logic [CFG_DATA_W-1:0] margin_data);
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_MEAN_RADIUS;
        cfg_data <= mean;
        @(posedge clk);
        cfg_index <= CFG_DEFECT_MARGIN;
        cfg_data <= margin_data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        trk_mean = mean[RADIUS_W-1:0];
        // Only the low bits of the margin write land in the register.
        trk_margin = margin_data[MARGIN_W-1:0];
        @(posedge clk);
    endtask

    // Result side: compares every accepted result transaction with the oldest
    // expectation and draws a fresh stall after each one. The stall counts
    // down whether or not a result is waiting, so it lands on any cycle.
    always @(posedge clk)
    begin : result_check
        int next_stall;
        run_t got;
        run_t want;
        if (out_valid && out_ready)
        begin
            got = '{run_start, run_end, run_count, run_depth, last_of_item};
            if (pending_runs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected run: start=%0d end=%0d count=%0d depth=%0d last=%0d",
                             got.run_start, got.run_end, got.run_count, got.run_depth,
                             got.last);
            end
            else
            begin
                want = pending_runs.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("run mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                 want.run_start, want.run_end, want.run_count,
                                 want.run_depth, want.last, got.run_start, got.run_end,
                                 got.run_count, got.run_depth, got.last);
                end
            end
            // Now and then switch between stalling and taking every result.
            if ($urandom_range(49, 0) == 0)
                rx_burst = ($urandom_range(2, 0) == 0);
            next_stall = rx_burst ? 0 : $urandom_range(16, 0);
        end
        else
        begin
            next_stall = (stall_left > 0) ? stall_left - 1 : 0;
        end
        stall_left <= next_stall;
        out_ready <= (next_stall == 0);
    end

    // Watchdog: a long stretch without any transaction means the block hung
    // or lost a result.
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int len;
        int roll;
        rev_style_t style;
        logic [31:0] raw_mean;
        logic [31:0] raw_margin;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset settings.
        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(DIRECTED_ROWS[i].radius, DIRECTED_ROWS[i].fin,
                        DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].first,
                        DIRECTED_ROWS[i].second);
        settle();

        // Random phases: register extremes first, then the reset values, then
        // random settings whose margin writes carry stray upper bits.
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            raw_mean = $urandom;
            raw_margin = $urandom;
            case (phase)
                0: write_config(RADIUS_MAX, '0);
                1: write_config('0, '0);
                2: write_config(RADIUS_MAX, {CFG_DATA_W{1'b1}});
                3: write_config(20'd65535, 20'd65535);
                4: write_config(MEAN_RADIUS_RESET, CFG_DATA_W'(DEFECT_MARGIN_RESET));
                default: write_config(raw_mean[CFG_DATA_W-1:0], raw_margin[CFG_DATA_W-1:0]);
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(19, 0);
                if (roll < 15)
                    len = $urandom_range(24, 1);
                else
                    len = $urandom_range(120, 25);
                roll = $urandom_range(19, 0);
                if (roll < 10)
                    style = STYLE_RUNS;
                else if (roll < 16)
                    style = STYLE_WRAP;
                else
                    style = STYLE_NOISE;
                send_revolution(len, style);
            end
            settle();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> below_mean_run_detector.f
hdl/bmrd_pkg.sv
hdl/bmrd_core.sv
hdl/bmrd_out_queue.sv
hdl/below_mean_run_detector.sv
dv/tb_top.sv
